>>> rtl/tcrl_pkg.sv
// Shared types and constants for the time and composition run lookup.
// Used by the search units and the top level; no dependencies.
package tcrl_pkg;

    localparam int TIME_DEPTH = 1024;
    localparam int COMP_DEPTH = 1024;

    localparam int TIME_AW = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;
    localparam int COMP_AW = (COMP_DEPTH > 1) ? $clog2(COMP_DEPTH) : 1;
    localparam int TIME_CW = $clog2(TIME_DEPTH + 1);
    localparam int COMP_CW = $clog2(COMP_DEPTH + 1);
    // Count and address width of the search units covers both tables.
    localparam int SRCH_W = (TIME_CW > COMP_CW) ? TIME_CW : COMP_CW;

    localparam logic [2:0] ACT_CLR_TIME  = 3'd0;
    localparam logic [2:0] ACT_LOAD_TIME = 3'd1;
    localparam logic [2:0] ACT_CLR_COMP  = 3'd2;
    localparam logic [2:0] ACT_LOAD_COMP = 3'd3;
    localparam logic [2:0] ACT_QUERY     = 3'd4;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_OVERFL  = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;
    localparam logic [2:0] ST_ANSWER  = 3'd6;

    typedef struct packed {
        logic [31:0] first;
        logic [63:0] start;
        logic [31:0] delta;
    } t_time_run;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] length;
        logic [32:0] offset;
    } t_comp_run;

    typedef struct packed {
        logic rd_en;
        logic done;
        logic found;
    } t_srch_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_FETCH,
        S_DONE
    } t_srch_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_EXEC,
        C_MUL,
        C_ACC,
        C_SRCH,
        C_QMUL,
        C_QADD,
        C_OUT
    } t_ctl_state;

endpackage

>>> rtl/tcrl_ram.sv
// Simple dual-port synchronous memory, one write and one registered read port.
// Generic; no package dependencies.
module tcrl_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [(1 << AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tcrl_search.sv
// Binary search over the first-sample field of one run memory.
// Depends on tcrl_pkg; drives the read port of a tcrl_ram.
module tcrl_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tcrl_pkg::SRCH_W-1:0] i_count,
    input  logic [31:0]               i_index,
    input  logic [31:0]               i_first,
    output logic [tcrl_pkg::SRCH_W-1:0] o_addr,
    output tcrl_pkg::t_srch_stat      o_stat
);

    tcrl_pkg::t_srch_state r_state, n_state;
    logic [tcrl_pkg::SRCH_W-1:0] r_lo, r_hi, r_mid;
    logic [tcrl_pkg::SRCH_W:0]   mid_sum;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcrl_pkg::S_IDLE:  if (i_start) n_state = tcrl_pkg::S_PROBE;
            tcrl_pkg::S_PROBE: begin
                if (r_lo < r_hi) n_state = tcrl_pkg::S_CMP;
                else n_state = tcrl_pkg::S_FETCH;
            end
            tcrl_pkg::S_CMP:   n_state = tcrl_pkg::S_PROBE;
            tcrl_pkg::S_FETCH: n_state = tcrl_pkg::S_DONE;
            tcrl_pkg::S_DONE:  if (i_start) n_state = tcrl_pkg::S_PROBE;
            default:           n_state = tcrl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stat.rd_en = (r_state == tcrl_pkg::S_PROBE);
        o_stat.done  = (r_state == tcrl_pkg::S_DONE);
        o_stat.found = (r_lo != '0);
        // Probe the midpoint while the window is open, else fetch run lo-1.
        if (r_lo < r_hi) begin
            o_addr = mid_sum[tcrl_pkg::SRCH_W:1];
        end else begin
            o_addr = r_lo - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcrl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == tcrl_pkg::S_IDLE || r_state == tcrl_pkg::S_DONE)) begin
            r_lo <= '0;
            r_hi <= i_count;
        end else if (r_state == tcrl_pkg::S_PROBE) begin
            r_mid <= mid_sum[tcrl_pkg::SRCH_W:1];
        end else if (r_state == tcrl_pkg::S_CMP) begin
            if (i_first <= i_index) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
    end

endmodule

>>> rtl/time_and_composition_run_lookup.sv
// Top level: command sequencer, run counters and the two run memories.
// Depends on tcrl_pkg, tcrl_ram and tcrl_search.
//
//  channel   signals                                      direction
//  input     i_in_valid, o_in_stall, i_action..index      in
//  output    o_out_valid, i_out_stall, o_status..total    out
//  config    i_cfg_we, i_cfg_wdata                        in
//
// One word is in flight at a time. Clears and composition loads execute and then
// output; stored time loads multiply, then accumulate, before output. A query runs
// both binary searches side by side, each probe a read on the memory read port
// then a compare, plus one fetch. Reset empties both tables at once; the memories
// need no clearing. A result waits in the output registers while i_out_stall is
// high, and the input stalls meanwhile.
module time_and_composition_run_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_action,
    input  logic [31:0]        i_run_count,
    input  logic [31:0]        i_run_value,
    input  logic [31:0]        i_sample_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [63:0]        o_decode_time,
    output logic [31:0]        o_sample_duration,
    output logic signed [32:0] o_composition_offset,
    output logic [63:0]        o_total_duration,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    tcrl_pkg::t_ctl_state r_state, n_state;

    logic        r_signed;
    logic [2:0]  r_action;
    logic [31:0] r_count, r_value, r_index;

    logic [tcrl_pkg::TIME_CW-1:0] r_time_entries;
    logic [32:0]                  r_time_next;
    logic [63:0]                  r_time_acc;
    logic                         r_time_stop;
    logic [tcrl_pkg::COMP_CW-1:0] r_comp_entries;
    logic [32:0]                  r_comp_next;
    logic                         r_comp_stop;

    logic [63:0] r_prod;
    logic [2:0]  r_status;
    logic [63:0] r_dts;
    logic [31:0] r_dur;
    logic [32:0] r_cto;

    logic [2:0]  exec_status;
    logic        time_we, comp_we;
    logic [33:0] time_sum, comp_sum;
    logic [31:0] mul_a, mul_b;
    logic        srch_start;

    tcrl_pkg::t_time_run time_wdata, time_rdata;
    tcrl_pkg::t_comp_run comp_wdata, comp_rdata;
    tcrl_pkg::t_srch_stat tstat, cstat;
    logic [tcrl_pkg::SRCH_W-1:0] taddr, caddr;
    logic [32:0] comp_end;

    assign time_sum = {1'b0, r_time_next} + {2'b0, r_count};
    assign comp_sum = {1'b0, r_comp_next} + {2'b0, r_count};

    // Status and memory writes for the word being executed.
    always_comb begin
        exec_status = tcrl_pkg::ST_CLEARED;
        time_we     = 1'b0;
        comp_we     = 1'b0;
        case (r_action)
            tcrl_pkg::ACT_LOAD_TIME: begin
                if (r_time_stop) exec_status = tcrl_pkg::ST_IGNORED;
                else if (r_count == '0) exec_status = tcrl_pkg::ST_EMPTY;
                else if (time_sum[33:32] != 2'b0) exec_status = tcrl_pkg::ST_OVERFL;
                else if (r_time_entries >= tcrl_pkg::TIME_CW'(tcrl_pkg::TIME_DEPTH))
                    exec_status = tcrl_pkg::ST_FULL;
                else begin
                    exec_status = tcrl_pkg::ST_STORED;
                    time_we     = (r_state == tcrl_pkg::C_EXEC);
                end
            end
            tcrl_pkg::ACT_LOAD_COMP: begin
                if (r_comp_stop) exec_status = tcrl_pkg::ST_IGNORED;
                else if (r_count == '0) exec_status = tcrl_pkg::ST_EMPTY;
                else if (comp_sum[33:32] != 2'b0) exec_status = tcrl_pkg::ST_OVERFL;
                else if (r_comp_entries >= tcrl_pkg::COMP_CW'(tcrl_pkg::COMP_DEPTH))
                    exec_status = tcrl_pkg::ST_FULL;
                else begin
                    exec_status = tcrl_pkg::ST_STORED;
                    comp_we     = (r_state == tcrl_pkg::C_EXEC);
                end
            end
            tcrl_pkg::ACT_QUERY: exec_status = tcrl_pkg::ST_ANSWER;
            default:             exec_status = tcrl_pkg::ST_CLEARED;
        endcase
    end

    assign time_wdata.first  = r_time_next[31:0];
    assign time_wdata.start  = r_time_acc;
    assign time_wdata.delta  = r_value;
    assign comp_wdata.first  = r_comp_next[31:0];
    assign comp_wdata.length = r_count;
    assign comp_wdata.offset = {r_signed & r_value[31], r_value};

    assign srch_start = (r_state == tcrl_pkg::C_EXEC) && (r_action == tcrl_pkg::ACT_QUERY);

    tcrl_search u_time_srch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_count (tcrl_pkg::SRCH_W'(r_time_entries)),
        .i_index (r_index),
        .i_first (time_rdata.first),
        .o_addr  (taddr),
        .o_stat  (tstat)
    );

    tcrl_search u_comp_srch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_count (tcrl_pkg::SRCH_W'(r_comp_entries)),
        .i_index (r_index),
        .i_first (comp_rdata.first),
        .o_addr  (caddr),
        .o_stat  (cstat)
    );

    tcrl_ram #(.AW(tcrl_pkg::TIME_AW), .DW($bits(tcrl_pkg::t_time_run))) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (r_time_entries[tcrl_pkg::TIME_AW-1:0]),
        .i_wdata (time_wdata),
        .i_re    (tstat.rd_en),
        .i_raddr (taddr[tcrl_pkg::TIME_AW-1:0]),
        .o_rdata (time_rdata)
    );

    tcrl_ram #(.AW(tcrl_pkg::COMP_AW), .DW($bits(tcrl_pkg::t_comp_run))) u_comp_ram (
        .i_clk   (i_clk),
        .i_we    (comp_we),
        .i_waddr (r_comp_entries[tcrl_pkg::COMP_AW-1:0]),
        .i_wdata (comp_wdata),
        .i_re    (cstat.rd_en),
        .i_raddr (caddr[tcrl_pkg::COMP_AW-1:0]),
        .o_rdata (comp_rdata)
    );

    // One shared 32x32 multiplier: count*delta on time loads, offset-in-run*delta on queries.
    always_comb begin
        if (r_state == tcrl_pkg::C_QMUL) begin
            mul_a = r_index - time_rdata.first;
            mul_b = time_rdata.delta;
        end else begin
            mul_a = r_count;
            mul_b = r_value;
        end
    end

    assign comp_end = {1'b0, comp_rdata.first} + {1'b0, comp_rdata.length};

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcrl_pkg::C_IDLE: if (i_in_valid) n_state = tcrl_pkg::C_EXEC;
            tcrl_pkg::C_EXEC: begin
                if (r_action == tcrl_pkg::ACT_QUERY) n_state = tcrl_pkg::C_SRCH;
                else if (r_action == tcrl_pkg::ACT_LOAD_TIME &&
                         exec_status == tcrl_pkg::ST_STORED) n_state = tcrl_pkg::C_MUL;
                else if (r_action > tcrl_pkg::ACT_QUERY) n_state = tcrl_pkg::C_IDLE;
                else n_state = tcrl_pkg::C_OUT;
            end
            tcrl_pkg::C_MUL:  n_state = tcrl_pkg::C_ACC;
            tcrl_pkg::C_ACC:  n_state = tcrl_pkg::C_OUT;
            tcrl_pkg::C_SRCH: if (tstat.done && cstat.done) n_state = tcrl_pkg::C_QMUL;
            tcrl_pkg::C_QMUL: n_state = tcrl_pkg::C_QADD;
            tcrl_pkg::C_QADD: n_state = tcrl_pkg::C_OUT;
            tcrl_pkg::C_OUT:  if (!i_out_stall) n_state = tcrl_pkg::C_IDLE;
            default:          n_state = tcrl_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != tcrl_pkg::C_IDLE);
        o_out_valid = (r_state == tcrl_pkg::C_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tcrl_pkg::C_IDLE;
            r_signed       <= 1'b0;
            r_time_entries <= '0;
            r_time_next    <= '0;
            r_time_acc     <= '0;
            r_time_stop    <= 1'b0;
            r_comp_entries <= '0;
            r_comp_next    <= '0;
            r_comp_stop    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_signed <= i_cfg_wdata;
            end
            if (r_state == tcrl_pkg::C_EXEC) begin
                case (r_action)
                    tcrl_pkg::ACT_CLR_TIME: begin
                        r_time_entries <= '0;
                        r_time_next    <= '0;
                        r_time_acc     <= '0;
                        r_time_stop    <= 1'b0;
                    end
                    tcrl_pkg::ACT_CLR_COMP: begin
                        r_comp_entries <= '0;
                        r_comp_next    <= '0;
                        r_comp_stop    <= 1'b0;
                    end
                    tcrl_pkg::ACT_LOAD_TIME: begin
                        if (exec_status == tcrl_pkg::ST_OVERFL) r_time_stop <= 1'b1;
                        if (time_we) begin
                            r_time_entries <= r_time_entries + 1'b1;
                            r_time_next    <= time_sum[32:0];
                        end
                    end
                    tcrl_pkg::ACT_LOAD_COMP: begin
                        if (exec_status == tcrl_pkg::ST_OVERFL) r_comp_stop <= 1'b1;
                        if (comp_we) begin
                            r_comp_entries <= r_comp_entries + 1'b1;
                            r_comp_next    <= comp_sum[32:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == tcrl_pkg::C_ACC) begin
                r_time_acc <= r_time_acc + r_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcrl_pkg::C_IDLE && i_in_valid) begin
            r_action <= i_action;
            r_count  <= i_run_count;
            r_value  <= i_run_value;
            r_index  <= i_sample_index;
        end
        if (r_state == tcrl_pkg::C_MUL || r_state == tcrl_pkg::C_QMUL) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == tcrl_pkg::C_EXEC) begin
            r_status <= exec_status;
            r_dts    <= '0;
            r_dur    <= '0;
            r_cto    <= '0;
        end
        if (r_state == tcrl_pkg::C_QADD) begin
            if (tstat.found) begin
                r_dts <= time_rdata.start + r_prod;
                r_dur <= time_rdata.delta;
            end
            if (cstat.found && ({1'b0, r_index} < comp_end)) begin
                r_cto <= comp_rdata.offset;
            end
        end
    end

    assign o_status             = r_status;
    assign o_decode_time        = r_dts;
    assign o_sample_duration    = r_dur;
    assign o_composition_offset = r_cto;
    assign o_total_duration     = r_time_acc;

endmodule
